>>> rtl/core/assert_macros.svh
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");

`endif

>>> rtl/core/mee_pkg.sv
`timescale 1ns / 1ps

package mee_pkg;

	localparam int MAX_CODE_LENGTH = 8;
	localparam int RESULT_CAP      = 8;
	// elements per character after both caps
	localparam int ELEM_CAP = (MAX_CODE_LENGTH < RESULT_CAP) ? MAX_CODE_LENGTH : RESULT_CAP;
	localparam int CNT_W    = $clog2(ELEM_CAP + 1);
	localparam int PAT_W    = 8;
	localparam int IDX_W    = $clog2(PAT_W);
	localparam int LEN_W    = 4;

	localparam int TICK_W = 16;
	localparam int OFF_W  = 17;
	localparam int CHAR_W = 16;
	localparam int IN_W   = 16;
	localparam int OUT_W  = 40;

	localparam logic [CHAR_W-1:0] SPACE_CODE = 16'h0020;

	// element kinds
	localparam logic [1:0] EL_DOT  = 2'd0;
	localparam logic [1:0] EL_DASH = 2'd1;
	localparam logic [1:0] EL_GAP  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_DOT    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DASH   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LETTER = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD   = 8'd3;

	localparam logic [TICK_W-1:0] DOT_RST    = 16'd200;
	localparam logic [TICK_W-1:0] DASH_RST   = 16'd600;
	localparam logic [TICK_W-1:0] LETTER_RST = 16'd600;
	localparam logic [TICK_W-1:0] WORD_RST   = 16'd1400;

	typedef struct packed {
		logic             found;
		logic [PAT_W-1:0] pat;   // 1 = dash, msb element first
		logic [LEN_W-1:0] len;
	} code_t;

	// Character to Morse pattern lookup
	function automatic code_t code_lookup(input logic [CHAR_W-1:0] ch);
		code_t r;
		r = {1'b0, 8'h00, 4'd8};
		case (ch)
			16'h0410: r = {1'b1, 8'h01, 4'd2};
			16'h0411: r = {1'b1, 8'h08, 4'd4};
			16'h0412: r = {1'b1, 8'h03, 4'd3};
			16'h0413: r = {1'b1, 8'h06, 4'd3};
			16'h0414: r = {1'b1, 8'h04, 4'd3};
			16'h0415: r = {1'b1, 8'h00, 4'd1};
			16'h0416: r = {1'b1, 8'h01, 4'd4};
			16'h0417: r = {1'b1, 8'h0C, 4'd4};
			16'h0418: r = {1'b1, 8'h00, 4'd2};
			16'h0419: r = {1'b1, 8'h07, 4'd4};
			16'h041A: r = {1'b1, 8'h05, 4'd3};
			16'h041B: r = {1'b1, 8'h04, 4'd4};
			16'h041C: r = {1'b1, 8'h03, 4'd2};
			16'h041D: r = {1'b1, 8'h02, 4'd2};
			16'h041E: r = {1'b1, 8'h07, 4'd3};
			16'h041F: r = {1'b1, 8'h06, 4'd4};
			16'h0420: r = {1'b1, 8'h02, 4'd3};
			16'h0421: r = {1'b1, 8'h00, 4'd3};
			16'h0422: r = {1'b1, 8'h01, 4'd1};
			16'h0423: r = {1'b1, 8'h01, 4'd3};
			16'h0424: r = {1'b1, 8'h02, 4'd4};
			16'h0425: r = {1'b1, 8'h00, 4'd4};
			16'h0426: r = {1'b1, 8'h0A, 4'd4};
			16'h0427: r = {1'b1, 8'h0E, 4'd4};
			16'h0428: r = {1'b1, 8'h0F, 4'd4};
			16'h0429: r = {1'b1, 8'h0D, 4'd4};
			16'h042A: r = {1'b1, 8'h1B, 4'd5};
			16'h042B: r = {1'b1, 8'h0B, 4'd4};
			16'h042C: r = {1'b1, 8'h09, 4'd4};
			16'h042D: r = {1'b1, 8'h04, 4'd5};
			16'h042E: r = {1'b1, 8'h03, 4'd4};
			16'h042F: r = {1'b1, 8'h05, 4'd4};
			16'h0031: r = {1'b1, 8'h0F, 4'd5};
			16'h0032: r = {1'b1, 8'h07, 4'd5};
			16'h0033: r = {1'b1, 8'h03, 4'd5};
			16'h0034: r = {1'b1, 8'h01, 4'd5};
			16'h0035: r = {1'b1, 8'h00, 4'd5};
			16'h0036: r = {1'b1, 8'h10, 4'd5};
			16'h0037: r = {1'b1, 8'h18, 4'd5};
			16'h0038: r = {1'b1, 8'h1C, 4'd5};
			16'h0039: r = {1'b1, 8'h1E, 4'd5};
			16'h0030: r = {1'b1, 8'h1F, 4'd5};
			16'h002E: r = {1'b1, 8'h15, 4'd6};
			16'h002C: r = {1'b1, 8'h33, 4'd6};
			16'h003F: r = {1'b1, 8'h0C, 4'd6};
			16'h0027: r = {1'b1, 8'h1E, 4'd6};
			16'h0021: r = {1'b1, 8'h2B, 4'd6};
			16'h002F: r = {1'b1, 8'h12, 4'd5};
			16'h0028: r = {1'b1, 8'h16, 4'd5};
			16'h0029: r = {1'b1, 8'h2D, 4'd6};
			16'h0026: r = {1'b1, 8'h08, 4'd5};
			16'h003A: r = {1'b1, 8'h38, 4'd6};
			16'h003B: r = {1'b1, 8'h2A, 4'd6}; // corrected semicolon
			16'h003D: r = {1'b1, 8'h11, 4'd5};
			16'h002B: r = {1'b1, 8'h0A, 4'd5};
			16'h002D: r = {1'b1, 8'h21, 4'd6};
			16'h005F: r = {1'b1, 8'h0D, 4'd6};
			16'h0022: r = {1'b1, 8'h12, 4'd6};
			16'h0024: r = {1'b1, 8'h09, 4'd7};
			16'h0040: r = {1'b1, 8'h1A, 4'd6};
			default:  r = {1'b0, 8'h00, 4'd8}; // unknown or cancel: eight dots
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/morse_element_encoder_unit.sv
`timescale 1ns / 1ps
// Each accepted character's n elements (n = 1..8, a space is 1) are registered
// in the output register, one element per cycle while the sink is ready; no new
// character is accepted until the last element is loaded. The single element
// stage (duration select plus pause adder) sets that rate.
// Reset: sequencer idle, output empty, tick registers back to their defaults.
module morse_element_encoder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [mee_pkg::IN_W-1:0]     s_tdata,  // [15:0] char_code
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [mee_pkg::OUT_W-1:0]    m_tdata,  // element, on_ticks, off_ticks, zero pad
	output logic                         m_tlast,  // last
	output logic                         m_tuser,  // stop
	// configuration writes
	input  logic                         cfg_we,
	input  logic [mee_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mee_pkg::TICK_W-1:0]   cfg_data
);
	import mee_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic              state_q;
	logic [PAT_W-1:0]  pat_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              space_q;
	logic              stop_q;

	logic [TICK_W-1:0] dot_q, dash_q, letter_q, word_q;

	logic              out_valid_q;
	logic [1:0]        el_q;
	logic [TICK_W-1:0] on_q;
	logic [OFF_W-1:0]  off_q;
	logic              last_q;
	logic              stop_out_q;

	code_t             code;
	logic [CNT_W-1:0]  n_elem;
	logic              accept;
	logic              load_out;
	logic [CNT_W-1:0]  cnt_m1;
	logic              bit_dash;
	logic              is_last;
	logic [TICK_W-1:0] dur;
	logic [1:0]        el_nxt;
	logic [TICK_W-1:0] on_nxt;
	logic [OFF_W-1:0]  off_nxt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q    <= DOT_RST;
			dash_q   <= DASH_RST;
			letter_q <= LETTER_RST;
			word_q   <= WORD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DOT:    dot_q    <= cfg_data;
				CFG_DASH:   dash_q   <= cfg_data;
				CFG_LETTER: letter_q <= cfg_data;
				CFG_WORD:   word_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Table lookup and element count clamp
	always_comb begin
		code = code_lookup(s_tdata[CHAR_W-1:0]);
		if (code.len > LEN_W'(ELEM_CAP))
			n_elem = CNT_W'(ELEM_CAP);
		else
			n_elem = CNT_W'(code.len);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || m_tready);

	// Element stage: pick the next pattern bit, form its durations
	always_comb begin
		cnt_m1   = cnt_q - CNT_W'(1);
		bit_dash = pat_q[cnt_m1[IDX_W-1:0]];
		is_last  = (cnt_q == CNT_W'(1));
		dur      = bit_dash ? dash_q : dot_q;
		if (space_q) begin
			el_nxt  = EL_GAP;
			on_nxt  = '0;
			off_nxt = {1'b0, word_q};
		end else begin
			el_nxt  = bit_dash ? EL_DASH : EL_DOT;
			on_nxt  = dur;
			off_nxt = {1'b0, dur} + (is_last ? {1'b0, letter_q} : '0);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EMIT;
						cnt_q   <= (s_tdata[CHAR_W-1:0] == SPACE_CODE) ? CNT_W'(1) : n_elem;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						cnt_q <= cnt_m1;
						if (is_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Per-character payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pat_q   <= code.pat;
			space_q <= (s_tdata[CHAR_W-1:0] == SPACE_CODE);
			stop_q  <= !code.found && (s_tdata[CHAR_W-1:0] != SPACE_CODE);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			el_q       <= el_nxt;
			on_q       <= on_nxt;
			off_q      <= off_nxt;
			last_q     <= is_last;
			stop_out_q <= stop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - OFF_W - TICK_W - 2){1'b0}}, off_q, on_q, el_q};
	assign m_tlast  = last_q;
	assign m_tuser  = stop_out_q;

endmodule

>>> rtl/core/mee_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mee_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [mee_pkg::OUT_W-1:0]    m_tdata,
	input logic                         m_tlast,
	input logic                         m_tuser
);
	import mee_pkg::*;

	logic [OUT_W+1:0] m_bus;
	logic             m_stall;
	logic             m_gap;

	assign m_bus   = {m_tuser, m_tlast, m_tdata};
	assign m_stall = m_tvalid && !m_tready;
	assign m_gap   = m_tvalid && (m_tdata[1:0] == EL_GAP);

	// stalled result holds
	`ASSERT_PROP(a_stall_hold, clk, arst_n, m_stall |=> m_tvalid && $stable(m_bus))

	// element code 3 is never produced
	`ASSERT_NEVER(a_el_code, clk, arst_n, m_tvalid && m_tdata[1:0] == 2'd3)

	// word gap is dark, single and never a stop
	`ASSERT_PROP(a_gap_form, clk, arst_n, m_gap |-> m_tdata[17:2] == '0 && m_tlast && !m_tuser)

	// a stop character is sent as dots only
	`ASSERT_PROP(a_stop_dots, clk, arst_n, m_tvalid && m_tuser |-> m_tdata[1:0] == EL_DOT)

	// one character at a time: busy right after an accept
	`ASSERT_PROP(a_busy, clk, arst_n, s_tvalid && s_tready |=> !s_tready)

endmodule

bind morse_element_encoder_unit mee_checker u_mee_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
